// ----- hdl/u8d_pkg.sv -----
package u8d_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] SurrogateLo = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpWidth-1:0] MinLen2     = 21'h000080;
  localparam logic [CpWidth-1:0] MinLen3     = 21'h000800;
  localparam logic [CpWidth-1:0] MinLen4     = 21'h010000;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_TRAIL,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_e;

  // One classified byte; data keeps the low seven bits of the raw byte.
  typedef struct packed {
    byte_class_e cls;
    logic [6:0]  data;
  } byte_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ----- hdl/u8d_front.sv -----
module u8d_front
  import u8d_pkg::*;
(
  input  logic        in_valid_i,
  input  logic [7:0]  byte_in_i,
  input  queue_stat_t q_stat_i,
  output logic        in_stall_o,
  output logic        push_o,
  output byte_rec_t   rec_o
);

  byte_class_e cls;

  always_comb begin
    if (byte_in_i[7] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (byte_in_i[7:6] == 2'b10) begin
      cls = CLS_TRAIL;
    end else if (byte_in_i[7:5] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (byte_in_i[7:4] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (byte_in_i[7:3] == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_INVALID;
    end
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;
  assign rec_o.cls  = cls;
  assign rec_o.data = byte_in_i[6:0];

endmodule

// ----- hdl/u8d_queue.sv -----
module u8d_queue
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  byte_rec_t   rec_i,
  input  logic        pop_i,
  output byte_rec_t   rec_o,
  output queue_stat_t stat_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  byte_rec_t          mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CountW'(Depth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CountW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ----- hdl/u8d_back.sv -----
module u8d_back
  import u8d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  input  byte_rec_t          rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic               bad_sequence_o,
  output logic               last_of_run_o
);

  logic [CpWidth-1:0] part_q, part_d;
  logic [2:0]         exp_q, exp_d;
  logic [2:0]         seen_q, seen_d;
  logic               out_valid_q, out_valid_d;
  logic [CpWidth-1:0] cp_q, cp_d;
  logic               bad_q, bad_d;
  logic               last_q, last_d;

  logic               out_free, take, emit;
  logic [CpWidth-1:0] shifted;
  logic [2:0]         seen_inc;
  logic [CpWidth-1:0] min_val;
  logic               cp_ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = rec_valid_i && out_free;
  assign shifted  = {part_q[CpWidth-7:0], rec_i.data[5:0]};
  assign seen_inc = seen_q + 3'd1;

  always_comb begin
    unique case (exp_q)
      Len2:    min_val = MinLen2;
      Len3:    min_val = MinLen3;
      default: min_val = MinLen4;
    endcase
  end

  assign cp_ok = (shifted >= min_val) && (shifted <= CpMax) &&
                 !((shifted >= SurrogateLo) && (shifted <= SurrogateHi));

  always_comb begin
    part_d = part_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    emit   = 1'b0;
    pop_o  = 1'b0;
    cp_d   = cp_q;
    bad_d  = bad_q;
    last_d = last_q;
    if (take) begin
      if (exp_q != LenNone) begin
        if (rec_i.cls == CLS_TRAIL) begin
          pop_o = 1'b1;
          if (seen_inc >= exp_q) begin
            emit   = 1'b1;
            cp_d   = cp_ok ? shifted : Replacement;
            bad_d  = !cp_ok;
            last_d = 1'b1;
            part_d = '0;
            exp_d  = LenNone;
            seen_d = '0;
          end else begin
            part_d = shifted;
            seen_d = seen_inc;
          end
        end else begin
          // A non-trailing byte breaks the open sequence. The record stays at
          // the queue head and is handled again as a fresh start on the next take.
          // Only a new leader gives no second result.
          emit   = 1'b1;
          cp_d   = Replacement;
          bad_d  = 1'b1;
          last_d = (rec_i.cls == CLS_LEAD2) || (rec_i.cls == CLS_LEAD3) ||
                   (rec_i.cls == CLS_LEAD4);
          part_d = '0;
          exp_d  = LenNone;
          seen_d = '0;
        end
      end else begin
        pop_o = 1'b1;
        unique case (rec_i.cls)
          CLS_ASCII: begin
            emit   = 1'b1;
            cp_d   = {{(CpWidth-7){1'b0}}, rec_i.data};
            bad_d  = 1'b0;
            last_d = 1'b1;
          end
          CLS_LEAD2: begin
            part_d = {{(CpWidth-5){1'b0}}, rec_i.data[4:0]};
            exp_d  = Len2;
            seen_d = 3'd1;
          end
          CLS_LEAD3: begin
            part_d = {{(CpWidth-4){1'b0}}, rec_i.data[3:0]};
            exp_d  = Len3;
            seen_d = 3'd1;
          end
          CLS_LEAD4: begin
            part_d = {{(CpWidth-3){1'b0}}, rec_i.data[2:0]};
            exp_d  = Len4;
            seen_d = 3'd1;
          end
          default: begin
            emit   = 1'b1;
            cp_d   = Replacement;
            bad_d  = 1'b1;
            last_d = 1'b1;
          end
        endcase
      end
    end
    out_valid_d = out_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= '0;
      exp_q       <= LenNone;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      part_q      <= part_d;
      exp_q       <= exp_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cp_q   <= cp_d;
      bad_q  <= bad_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = cp_q;
  assign bad_sequence_o = bad_q;
  assign last_of_run_o  = last_q;

endmodule

// ----- hdl/utf8_stream_decoder_core.sv -----
// UTF-8 stream decoder: takes one byte per transaction and returns decoded
// code points, with U+FFFD and bad_sequence set for stray trailing bytes,
// invalid leaders, broken, overlong, surrogate or out-of-range sequences.
// The front end classifies each byte and writes it into a small queue; the
// back end gathers multi-byte sequences and drives a registered output. A
// byte is accepted every cycle while the queue is not full. A result leaves
// when it is complete and the output is not stalled. A non-trailing byte
// that breaks an open sequence holds the queue head for a second back-end
// pass (the replacement, then the fresh start), which the QueueDepth-entry
// queue absorbs. An unfinished sequence at stream end produces nothing.
module utf8_stream_decoder_core
  import u8d_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic               bad_sequence_o,
  output logic               last_of_run_o
);

  queue_stat_t q_stat;
  byte_rec_t   push_rec, head_rec;
  logic        push, pop;

  u8d_front u_front (
    .in_valid_i (in_valid_i),
    .byte_in_i  (byte_in_i),
    .q_stat_i   (q_stat),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (head_rec),
    .stat_o (q_stat)
  );

  u8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (!q_stat.empty),
    .rec_i          (head_rec),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .bad_sequence_o (bad_sequence_o),
    .last_of_run_o  (last_of_run_o)
  );

`ifndef SYNTH
  // A new result can only come from a byte that was waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_stat.empty))
    else $error("result appeared without a queued byte");

  // A clean result is never a surrogate and never above the code space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bad_sequence_o) |->
      ((code_point_o <= CpMax) &&
       !((code_point_o >= SurrogateLo) && (code_point_o <= SurrogateHi))))
    else $error("clean result outside the valid code point range");

  // Only the replacement for a broken sequence is followed by a second result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> (bad_sequence_o && (code_point_o == Replacement)))
    else $error("non-final result that is not a replacement");
`endif

endmodule
